@@ rtl/core/lpt_pkg.sv @@
// ----------------------------------------------------------------------------
// lpt_pkg
// Shared types and constants for the LRU page tracker: controller states,
// controller-to-datapath command group and configuration reset values.
// ----------------------------------------------------------------------------
package lpt_pkg;

    // Field widths fixed by the interface
    localparam int PAGE_W     = 32;
    localparam int CAP_W      = 4;
    localparam int RANK_W     = 3;
    localparam int OCC_W      = 4;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 4'd5;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_UPDATE
    } lpt_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture the accessed page
        logic compare;   // register the tag match vector
        logic update;    // reorder the list and register the result
    } lpt_cmd_t;

endpackage

@@ rtl/core/lpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpt_ctrl
// Sequencer for one access: capture, compare against all held entries,
// then update the recency list and issue the result.
// ----------------------------------------------------------------------------
module lpt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output lpt_pkg::lpt_cmd_t cmd
);

    lpt_pkg::lpt_state_t state_reg;
    lpt_pkg::lpt_state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through compare and update, issue datapath commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        busy        = 1'b1;
        unique case (state_reg)
            lpt_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = lpt_pkg::ST_COMPARE;
                end
            end
            lpt_pkg::ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = lpt_pkg::ST_UPDATE;
            end
            lpt_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = lpt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lpt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/lpt_datapath.sv @@
// ----------------------------------------------------------------------------
// lpt_datapath
// Recency list storage, parallel tag compare, priority select of the hit,
// list shift and result registers. Also holds the capacity register.
// ----------------------------------------------------------------------------
module lpt_datapath
#(
    parameter int MAX_ENTRIES = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpt_pkg::lpt_cmd_t             cmd,
    input  logic                          capacity_we,
    input  logic [lpt_pkg::CAP_W-1:0]     capacity_data,
    input  logic [lpt_pkg::PAGE_W-1:0]    access_page,
    output logic                          done,
    output logic                          hit,
    output logic [lpt_pkg::RANK_W-1:0]    hit_rank,
    output logic                          evicted_valid,
    output logic [lpt_pkg::PAGE_W-1:0]    evicted_page,
    output logic [lpt_pkg::OCC_W-1:0]     occupancy
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [lpt_pkg::CAP_W-1:0]  capacity_reg;
    logic [lpt_pkg::PAGE_W-1:0] page_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [MAX_ENTRIES-1:0]     match_reg;
    logic [MAX_ENTRIES-1:0]     match_next;
    logic [lpt_pkg::PAGE_W-1:0] entry_reg  [MAX_ENTRIES];
    logic [lpt_pkg::PAGE_W-1:0] entry_next [MAX_ENTRIES];

    logic                       found;
    logic [IDX_W-1:0]           rank;
    logic [CNT_W-1:0]           eff_cap;
    logic                       not_full;
    logic [CNT_W-1:0]           shift_limit;
    logic [IDX_W-1:0]           last_idx;
    logic                       evict;

    logic                       done_reg;
    logic                       hit_reg;
    logic [lpt_pkg::RANK_W-1:0] hit_rank_reg;
    logic                       evicted_valid_reg;
    logic [lpt_pkg::PAGE_W-1:0] evicted_page_reg;
    logic [lpt_pkg::OCC_W-1:0]  occupancy_reg;

    // Clamp the capacity register into 1..MAX_ENTRIES
    always_comb
    begin
        priority if (capacity_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (32'(capacity_reg) > 32'(MAX_ENTRIES))
        begin
            eff_cap = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = CNT_W'(capacity_reg);
        end
    end

    // Compare the page against every held entry
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            match_next[i] = (entry_reg[i] == page_reg) && (CNT_W'(i) < count_reg);
        end
    end

    // Pick the most recent match
    always_comb
    begin
        found = 1'b0;
        rank  = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                found = 1'b1;
                rank  = IDX_W'(i);
            end
        end
    end

    // Decide how far the list shifts and whether the tail drops out
    always_comb
    begin
        not_full = count_reg < eff_cap;
        last_idx = IDX_W'(count_reg - CNT_W'(1));
        evict    = 1'b0;
        priority if (found)
        begin
            shift_limit = CNT_W'(rank);
            count_next  = count_reg;
        end
        else if (not_full)
        begin
            shift_limit = count_reg;
            count_next  = count_reg + CNT_W'(1);
        end
        else
        begin
            shift_limit = count_reg - CNT_W'(1);
            count_next  = count_reg;
            evict       = 1'b1;
        end
    end

    // Shift entries toward the back up to the limit, new page at the front
    assign entry_next[0] = page_reg;
    generate
        for (genvar g = 1; g < MAX_ENTRIES; g++)
        begin : g_shift
            assign entry_next[g] = (CNT_W'(g) <= shift_limit) ? entry_reg[g-1] : entry_reg[g];
        end
    endgenerate

    // Hold the entry list
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                entry_reg[i] <= entry_next[i];
            end
        end
    end

    // Capture the accessed page and the match vector
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg <= access_page;
        end
        if (cmd.compare)
        begin
            match_reg <= match_next;
        end
    end

    // Control state: capacity, occupancy and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lpt_pkg::CAPACITY_RESET;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (capacity_we)
            begin
                capacity_reg <= capacity_data;
            end
            if (cmd.update)
            begin
                count_reg <= count_next;
            end
            done_reg <= cmd.update;
        end
    end

    // Register the result beat
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            hit_reg           <= found;
            hit_rank_reg      <= lpt_pkg::RANK_W'(rank);
            evicted_valid_reg <= evict;
            evicted_page_reg  <= evict ? entry_reg[last_idx] : '0;
            occupancy_reg     <= lpt_pkg::OCC_W'(count_next);
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign hit_rank      = hit_rank_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign occupancy     = occupancy_reg;

endmodule

@@ rtl/core/lru_page_tracker.sv @@
// Sequence: start is taken in idle, where the page is captured; the compare
//   state registers the match vector and the update state registers the result.
// A new access is taken only in idle, after the capture, compare and update
//   sequence; busy is high in the compare and update states.
// The result beat lasts one cycle and is not held off by the receiver.
// Reset: list empty, occupancy count zero, capacity register back to 5.
// ----------------------------------------------------------------------------
// lru_page_tracker
// Fully associative LRU page tracker: keeps page numbers in recency order
// and reports hit, hit rank, evicted page and occupancy for each access.
// ----------------------------------------------------------------------------
module lru_page_tracker
#(
    parameter int MAX_ENTRIES = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lpt_pkg::PAGE_W-1:0]    access_page,
    input  logic                          capacity_we,
    input  logic [lpt_pkg::CAP_W-1:0]     capacity_data,
    output logic                          done,
    output logic                          hit,
    output logic [lpt_pkg::RANK_W-1:0]    hit_rank,
    output logic                          evicted_valid,
    output logic [lpt_pkg::PAGE_W-1:0]    evicted_page,
    output logic [lpt_pkg::OCC_W-1:0]     occupancy
);

    lpt_pkg::lpt_cmd_t cmd;

    // Sequence each access
    lpt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Hold the list and produce the result beat
    lpt_datapath
    #(
        .MAX_ENTRIES (MAX_ENTRIES)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .capacity_we   (capacity_we),
        .capacity_data (capacity_data),
        .access_page   (access_page),
        .done          (done),
        .hit           (hit),
        .hit_rank      (hit_rank),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .occupancy     (occupancy)
    );

endmodule
